// File: sv/dfr_pkg.sv
package dfr_pkg;

  // Default payload capacity of one frame.
  localparam int MAX_PAYLOAD_DEF = 32;

  // CRC-8 generator polynomial, MSB first.
  localparam logic [7:0] CRC_POLY = 8'h07;

  // Reset values of the frame delimiter registers.
  localparam logic [7:0] START_BYTE_RST = 8'h02;
  localparam logic [7:0] END_BYTE_RST   = 8'h03;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_READY      = 2'd1,
    ST_ERROR      = 2'd2
  } status_t;

  // One entry of the queue between the parser and the readout.
  typedef struct packed {
    status_t     status;
    logic [7:0]  command;
    logic [5:0]  length;
  } desc_t;

  // One byte of CRC-8, no reflection and no final xor.
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: sv/dfr_front.sv
module dfr_front #(
  parameter int MAX_PAYLOAD = dfr_pkg::MAX_PAYLOAD_DEF,
  parameter int AW = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      start_byte,
  input  logic [7:0]      end_byte,
  input  logic            byte_en,
  input  logic [7:0]      rx_byte,
  output dfr_pkg::desc_t  desc,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output logic [7:0]      wr_data,
  output logic            frame_set
);

  typedef enum logic [5:0] {
    PH_WAIT    = 6'b000001,
    PH_LENGTH  = 6'b000010,
    PH_COMMAND = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CRC     = 6'b010000,
    PH_END     = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [5:0]  len_r, len_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  got_r, got_nxt;
  logic [5:0]  cnt_inc;
  logic [7:0]  crc_upd;

  assign cnt_inc = cnt_r + 6'd1;
  assign crc_upd = dfr_pkg::crc8_step(crc_r, rx_byte);

  assign wr_addr = cnt_r[AW-1:0];
  assign wr_data = rx_byte;

  // Parse one byte and classify it into a queue entry.
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    got_nxt   = got_r;
    desc      = '{status: dfr_pkg::ST_INCOMPLETE, command: 8'd0, length: 6'd0};
    wr_en     = 1'b0;
    frame_set = 1'b0;
    unique case (phase_r)
      PH_WAIT: begin
        if (rx_byte == start_byte) begin
          phase_nxt = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (rx_byte > 8'(MAX_PAYLOAD)) begin
          desc.status = dfr_pkg::ST_ERROR;
          phase_nxt   = PH_WAIT;
          len_nxt     = 6'd0;
          cmd_nxt     = 8'd0;
          cnt_nxt     = 6'd0;
          crc_nxt     = 8'd0;
          got_nxt     = 8'd0;
        end else begin
          len_nxt   = rx_byte[5:0];
          cnt_nxt   = 6'd0;
          crc_nxt   = dfr_pkg::crc8_step(8'd0, rx_byte);
          phase_nxt = PH_COMMAND;
        end
      end
      PH_COMMAND: begin
        cmd_nxt   = rx_byte;
        crc_nxt   = crc_upd;
        phase_nxt = (len_r == 6'd0) ? PH_CRC : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        wr_en   = (cnt_r < 6'(MAX_PAYLOAD));
        cnt_nxt = cnt_inc;
        crc_nxt = crc_upd;
        if (cnt_inc >= len_r) begin
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        got_nxt   = rx_byte;
        phase_nxt = PH_END;
      end
      PH_END: begin
        if (rx_byte == end_byte && got_r == crc_r) begin
          desc      = '{status: dfr_pkg::ST_READY, command: cmd_r, length: len_r};
          frame_set = (len_r != 6'd0);
          phase_nxt = PH_WAIT;
        end else begin
          desc.status = dfr_pkg::ST_ERROR;
          phase_nxt   = (rx_byte == start_byte) ? PH_LENGTH : PH_WAIT;
        end
        len_nxt = 6'd0;
        cmd_nxt = 8'd0;
        cnt_nxt = 6'd0;
        crc_nxt = 8'd0;
        got_nxt = 8'd0;
      end
      default: begin
        desc.status = dfr_pkg::ST_ERROR;
        phase_nxt   = PH_WAIT;
        len_nxt     = 6'd0;
        cmd_nxt     = 8'd0;
        cnt_nxt     = 6'd0;
        crc_nxt     = 8'd0;
        got_nxt     = 8'd0;
      end
    endcase
  end

  // Parser state advances once per transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      len_r   <= 6'd0;
      cmd_r   <= 8'd0;
      cnt_r   <= 6'd0;
      crc_r   <= 8'd0;
      got_r   <= 8'd0;
    end else if (byte_en) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cmd_r   <= cmd_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      got_r   <= got_nxt;
    end
  end

endmodule

// File: sv/dfr_queue.sv
module dfr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dfr_pkg::desc_t  push_desc,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output dfr_pkg::desc_t  head
);

  dfr_pkg::desc_t  entry_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = entry_r[rd_ptr_r];

  // Two-entry circular buffer of descriptors.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  // Descriptor storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// File: sv/dfr_back.sv
module dfr_back #(
  parameter int MAX_PAYLOAD = dfr_pkg::MAX_PAYLOAD_DEF,
  parameter int AW = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [7:0]      wr_data,
  input  logic            q_not_empty,
  input  dfr_pkg::desc_t  q_head,
  output logic            q_pop,
  output logic            frame_done,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      out_status,
  output logic [7:0]      out_command,
  output logic [5:0]      out_payload_len,
  output logic [7:0]      out_payload_byte,
  output logic [4:0]      out_byte_index,
  output logic            out_last
);

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_FETCH = 3'b010,
    B_EMIT  = 3'b100
  } bstate_t;

  bstate_t     state_r, state_nxt;
  logic [7:0]  mem [MAX_PAYLOAD];
  logic [7:0]  rdata_r;
  logic [5:0]  idx_r, idx_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [5:0]  len_r, len_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;
  logic        out_load;
  logic        is_frame;
  logic        is_last;
  logic [1:0]  status_r, status_nxt;
  logic [7:0]  command_r, command_nxt;
  logic [5:0]  flen_r, flen_nxt;
  logic [7:0]  pbyte_r, pbyte_nxt;
  logic [4:0]  bidx_r, bidx_nxt;
  logic        last_r, last_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign is_frame = (q_head.status == dfr_pkg::ST_READY) && (q_head.length != 6'd0);
  assign is_last  = ((idx_r + 6'd1) == len_r);

  // Payload memory: written by the parser, read one entry per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[idx_r[AW-1:0]];
  end

  // Readout sequencer and output register loading.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cmd_nxt       = cmd_r;
    len_nxt       = len_r;
    q_pop         = 1'b0;
    frame_done    = 1'b0;
    out_load      = 1'b0;
    status_nxt    = status_r;
    command_nxt   = command_r;
    flen_nxt      = flen_r;
    pbyte_nxt     = pbyte_r;
    bidx_nxt      = bidx_r;
    last_nxt      = last_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_not_empty && is_frame) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head.command;
          len_nxt   = q_head.length;
          idx_nxt   = 6'd0;
          state_nxt = B_FETCH;
        end else if (q_not_empty && out_free) begin
          q_pop       = 1'b1;
          out_load    = 1'b1;
          status_nxt  = q_head.status;
          command_nxt = q_head.command;
          flen_nxt    = 6'd0;
          pbyte_nxt   = 8'd0;
          bidx_nxt    = 5'd0;
          last_nxt    = 1'b1;
        end
      end
      B_FETCH: begin
        state_nxt = B_EMIT;
      end
      B_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          status_nxt  = dfr_pkg::ST_READY;
          command_nxt = cmd_r;
          flen_nxt    = len_r;
          pbyte_nxt   = rdata_r;
          bidx_nxt    = idx_r[4:0];
          last_nxt    = is_last;
          if (is_last) begin
            frame_done = 1'b1;
            state_nxt  = B_IDLE;
          end else begin
            idx_nxt   = idx_r + 6'd1;
            state_nxt = B_FETCH;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Frame context and output payload registers.
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    cmd_r     <= cmd_nxt;
    len_r     <= len_nxt;
    status_r  <= status_nxt;
    command_r <= command_nxt;
    flen_r    <= flen_nxt;
    pbyte_r   <= pbyte_nxt;
    bidx_r    <= bidx_nxt;
    last_r    <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_command      = command_r;
  assign out_payload_len  = flen_r;
  assign out_payload_byte = pbyte_r;
  assign out_byte_index   = bidx_r;
  assign out_last         = last_r;

endmodule

// File: sv/framed_byte_deframer_crc8.sv
// A byte's status result goes into the two-entry queue, then into the output register.
// One byte is taken per cycle while the queue has room and no frame is pending readout.
// A good frame with a payload is read out byte by byte through the payload memory port;
// input stalls from the end byte's transfer until the frame's last result is registered.
// Reset (synchronous, rst_n low) returns the parser to waiting for the start byte, empties
// the queue and the output register, and sets the start and end bytes to 2 and 3.
module framed_byte_deframer_crc8 #(
  parameter int MAX_PAYLOAD = dfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [7:0]                    out_command,
  output logic [5:0]                    out_payload_len,
  output logic [7:0]                    out_payload_byte,
  output logic [4:0]                    out_byte_index,
  output logic                          out_last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic            in_xfer;
  logic [7:0]      start_byte_r;
  logic [7:0]      end_byte_r;
  logic            pending_r;
  dfr_pkg::desc_t  desc;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [7:0]      wr_data;
  logic            frame_set;
  logic            frame_done;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;
  dfr_pkg::desc_t  q_head;

  // Hold input while the queue is full or a frame still occupies the payload memory.
  assign in_stall = q_full || pending_r;
  assign in_xfer  = in_valid && !in_stall;

  // Delimiter configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= dfr_pkg::START_BYTE_RST;
      end_byte_r   <= dfr_pkg::END_BYTE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dfr_pkg::CFG_START_BYTE: start_byte_r <= cfg_data;
        dfr_pkg::CFG_END_BYTE:   end_byte_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame readout in progress flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
    end else if (in_xfer && frame_set) begin
      pending_r <= 1'b1;
    end else if (frame_done) begin
      pending_r <= 1'b0;
    end
  end

  dfr_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_byte (start_byte_r),
    .end_byte   (end_byte_r),
    .byte_en    (in_xfer),
    .rx_byte    (in_rx_byte),
    .desc       (desc),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .frame_set  (frame_set)
  );

  dfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_desc (desc),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  dfr_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .wr_en            (wr_en && in_xfer),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .q_not_empty      (q_not_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .frame_done       (frame_done),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_command      (out_command),
    .out_payload_len  (out_payload_len),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last)
  );

endmodule

// File: bench/tb_framed_byte_deframer_crc8.sv
module tb_framed_byte_deframer_crc8;

  localparam int PAYLOAD_CAP  = dfr_pkg::MAX_PAYLOAD_DEF;
  localparam int RANDOM_BYTES = 140;
  localparam int NUM_SETTINGS = 5;
  localparam int N_DIRECTED   = 25;

  // Parser phases of the frame decoder.
  typedef enum logic [2:0] {
    SEEK_START, GET_LENGTH, GET_COMMAND, GET_PAYLOAD, GET_CRC, GET_END
  } rx_phase_t;

  // One result transfer as seen on the output channel.
  typedef struct packed {
    dfr_pkg::status_t status;
    logic [7:0]       command;
    logic [5:0]       payload_len;
    logic [7:0]       payload_byte;
    logic [4:0]       byte_index;
    logic             last;
  } deframe_result_t;

  // How a stimulus row picks its byte: as written, or from the running CRC.
  typedef enum logic [1:0] {BYTE_RAW, BYTE_GOOD_CRC, BYTE_BAD_CRC} row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    logic [7:0]      value;
    logic            typed;
    deframe_result_t want;
  } stim_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  localparam deframe_result_t R_NONE  = '0;
  localparam deframe_result_t R_BUSY  =
    '{dfr_pkg::ST_INCOMPLETE, 8'h00, 6'd0, 8'h00, 5'd0, 1'b1};
  localparam deframe_result_t R_ERR   =
    '{dfr_pkg::ST_ERROR, 8'h00, 6'd0, 8'h00, 5'd0, 1'b1};
  localparam deframe_result_t R_EMPTY =
    '{dfr_pkg::ST_READY, 8'hA5, 6'd0, 8'h00, 5'd0, 1'b1};

  // Directed frames under the reset delimiters (start 0x02, end 0x03).
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // Idle bytes at both extremes, then a length one above the payload limit.
    '{BYTE_RAW, 8'h00, 1'b1, R_BUSY},
    '{BYTE_RAW, 8'hFF, 1'b1, R_BUSY},
    '{BYTE_RAW, 8'h02, 1'b1, R_BUSY},
    '{BYTE_RAW, 8'h21, 1'b1, R_ERR},
    // Good frame with an empty payload.
    '{BYTE_RAW, 8'h02, 1'b0, R_NONE},
    '{BYTE_RAW, 8'h00, 1'b0, R_NONE},
    '{BYTE_RAW, 8'hA5, 1'b0, R_NONE},
    '{BYTE_GOOD_CRC, 8'h00, 1'b0, R_NONE},
    '{BYTE_RAW, 8'h03, 1'b1, R_EMPTY},
    // One payload byte with a corrupted CRC.
    '{BYTE_RAW, 8'h02, 1'b0, R_NONE},
    '{BYTE_RAW, 8'h01, 1'b0, R_NONE},
    '{BYTE_RAW, 8'h00, 1'b0, R_NONE},
    '{BYTE_RAW, 8'hFF, 1'b0, R_NONE},
    '{BYTE_BAD_CRC, 8'h00, 1'b0, R_NONE},
    '{BYTE_RAW, 8'h03, 1'b1, R_ERR},
    // Start byte in the end position: error, then the parser resumes at the length.
    '{BYTE_RAW, 8'h02, 1'b0, R_NONE},
    '{BYTE_RAW, 8'h00, 1'b0, R_NONE},
    '{BYTE_RAW, 8'h7E, 1'b0, R_NONE},
    '{BYTE_GOOD_CRC, 8'h00, 1'b0, R_NONE},
    '{BYTE_RAW, 8'h02, 1'b1, R_ERR},
    // Resumed frame whose payload is the start byte itself.
    '{BYTE_RAW, 8'h01, 1'b0, R_NONE},
    '{BYTE_RAW, 8'h5A, 1'b0, R_NONE},
    '{BYTE_RAW, 8'h02, 1'b0, R_NONE},
    '{BYTE_GOOD_CRC, 8'h00, 1'b0, R_NONE},
    '{BYTE_RAW, 8'h03, 1'b0, R_NONE}
  };

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [dfr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                    cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic [7:0]                    in_rx_byte;
  logic                          out_valid;
  logic                          out_stall;
  logic [1:0]                    out_status;
  logic [7:0]                    out_command;
  logic [5:0]                    out_payload_len;
  logic [7:0]                    out_payload_byte;
  logic [4:0]                    out_byte_index;
  logic                          out_last;

  // Decoder state mirrored by the bench.
  logic [7:0] cur_start;
  logic [7:0] cur_end;
  rx_phase_t  rx_phase;
  logic [5:0] frm_len;
  logic [7:0] frm_cmd;
  logic [5:0] pay_cnt;
  logic [7:0] crc_acc;
  logic [7:0] crc_rcvd;
  logic [7:0] pay_mem [PAYLOAD_CAP];

  deframe_result_t step_results [$];
  deframe_result_t pending_results [$];

  int bytes_sent;
  int results_checked;
  int mismatches;
  int frames_good;
  int error_results;
  int burst_left;
  bit sender_steady;
  stall_mode_t stall_mode;
  int mode_left;

  framed_byte_deframer_crc8 dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_command      (out_command),
    .out_payload_len  (out_payload_len),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_last         (out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Bit-serial CRC-8, MSB first.
  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ b[i];
      r = {r[6:0], 1'b0} ^ (fb ? dfr_pkg::CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  function automatic void clear_frame();
    rx_phase = SEEK_START;
    frm_len  = '0;
    frm_cmd  = '0;
    pay_cnt  = '0;
    crc_acc  = '0;
    crc_rcvd = '0;
  endfunction

  // Advances the mirrored decoder by one byte and collects the results it causes.
  function automatic void deframe_step(input logic [7:0] b);
    step_results.delete();
    case (rx_phase)
      SEEK_START: begin
        if (b == cur_start) rx_phase = GET_LENGTH;
        step_results.push_back(R_BUSY);
      end
      GET_LENGTH: begin
        if (b > PAYLOAD_CAP) begin
          clear_frame();
          step_results.push_back(R_ERR);
        end else begin
          frm_len  = b[5:0];
          pay_cnt  = '0;
          crc_acc  = crc8_next(8'h00, b);
          rx_phase = GET_COMMAND;
          step_results.push_back(R_BUSY);
        end
      end
      GET_COMMAND: begin
        frm_cmd  = b;
        crc_acc  = crc8_next(crc_acc, b);
        rx_phase = (frm_len == 0) ? GET_CRC : GET_PAYLOAD;
        step_results.push_back(R_BUSY);
      end
      GET_PAYLOAD: begin
        if (pay_cnt < PAYLOAD_CAP) pay_mem[pay_cnt] = b;
        pay_cnt = pay_cnt + 6'd1;
        crc_acc = crc8_next(crc_acc, b);
        if (pay_cnt >= frm_len) rx_phase = GET_CRC;
        step_results.push_back(R_BUSY);
      end
      GET_CRC: begin
        crc_rcvd = b;
        rx_phase = GET_END;
        step_results.push_back(R_BUSY);
      end
      GET_END: begin
        if (b == cur_end && crc_rcvd == crc_acc) begin
          // A good frame is read out one payload byte per result.
          if (frm_len == 0) begin
            step_results.push_back('{dfr_pkg::ST_READY, frm_cmd, 6'd0, 8'h00, 5'd0, 1'b1});
          end else begin
            for (int k = 0; k < frm_len; k++) begin
              step_results.push_back('{dfr_pkg::ST_READY, frm_cmd, frm_len, pay_mem[k],
                                       5'(k), (k == frm_len - 1)});
            end
          end
          frames_good++;
          clear_frame();
        end else begin
          clear_frame();
          if (b == cur_start) rx_phase = GET_LENGTH;
          step_results.push_back(R_ERR);
        end
      end
      default: begin
        clear_frame();
        step_results.push_back(R_ERR);
      end
    endcase
    if (step_results[0].status == dfr_pkg::ST_ERROR) error_results++;
  endfunction

  // Offers one byte, waits for its transfer, records the expected results and
  // then idles the sender between bursts.
  task automatic send_byte(input logic [7:0] b, input logic typed, input deframe_result_t want);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    deframe_step(b);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
    bytes_sent++;
    if (!sender_steady) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Holds the sender until every expected result has been seen.
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both delimiter registers on consecutive edges.
  task automatic write_delimiters(input logic [7:0] start_val, input logic [7:0] end_val);
    cfg_we    <= 1'b1;
    cfg_index <= dfr_pkg::CFG_START_BYTE;
    cfg_data  <= start_val;
    @(posedge clk);
    cfg_index <= dfr_pkg::CFG_END_BYTE;
    cfg_data  <= end_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_start = start_val;
    cur_end   = end_val;
  endtask

  // Mostly well-formed frames with random content; some oversize lengths,
  // corrupted CRCs and wrong end bytes.
  task automatic send_frame(input int want_len);
    int         len;
    int         r;
    logic [7:0] crc_byte;
    logic [7:0] end_val;
    r = $urandom_range(0, 99);
    if (want_len >= 0) len = want_len;
    else if (r < 4) len = PAYLOAD_CAP;
    else if (r < 12) len = $urandom_range(PAYLOAD_CAP + 1, 255);
    else len = $urandom_range(0, 6);
    send_byte(cur_start, 1'b0, R_NONE);
    send_byte(8'(len), 1'b0, R_NONE);
    if (len > PAYLOAD_CAP) return;
    send_byte(8'($urandom), 1'b0, R_NONE);
    for (int i = 0; i < len; i++) send_byte(8'($urandom), 1'b0, R_NONE);
    crc_byte = crc_acc;
    if ($urandom_range(0, 9) == 0) crc_byte = crc_byte ^ 8'($urandom_range(1, 255));
    send_byte(crc_byte, 1'b0, R_NONE);
    r = $urandom_range(0, 99);
    if (r < 85) end_val = cur_end;
    else if (r < 93) end_val = cur_start;
    else end_val = 8'($urandom);
    send_byte(end_val, 1'b0, R_NONE);
  endtask

  function automatic void note_field(input string name, input logic [7:0] exp_v,
                                     input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endfunction

  // The receiver switches between free running, light and heavy stalling.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      mode_left  = $urandom_range(16, 96);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
      default:     out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // Every result transfer is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    deframe_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got status %0d command %0h",
                 $time, out_status, out_command);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        note_field("status", 8'(want.status), 8'(out_status));
        note_field("command", want.command, out_command);
        note_field("payload_len", 8'(want.payload_len), 8'(out_payload_len));
        note_field("payload_byte", want.payload_byte, out_payload_byte);
        note_field("byte_index", 8'(want.byte_index), 8'(out_byte_index));
        note_field("last", 8'(want.last), 8'(out_last));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [7:0] b;
    int         target;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = dfr_pkg::CFG_START_BYTE;
    cfg_data   = 8'h00;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    out_stall  = 1'b0;
    mode_left  = 0;
    stall_mode = STALL_NONE;
    burst_left = $urandom_range(1, 16);
    sender_steady = 1'b0;
    cur_start  = dfr_pkg::START_BYTE_RST;
    cur_end    = dfr_pkg::END_BYTE_RST;
    clear_frame();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows under the reset delimiters.
    for (int i = 0; i < N_DIRECTED; i++) begin
      case (DIRECTED[i].kind)
        BYTE_GOOD_CRC: b = crc_acc;
        BYTE_BAD_CRC:  b = crc_acc ^ 8'h01;
        default:       b = DIRECTED[i].value;
      endcase
      send_byte(b, DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random traffic under several delimiter settings.
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      drain_outputs();
      case (s)
        0: write_delimiters(8'h00, 8'hFF);
        1: write_delimiters(8'hFF, 8'h00);
        2: write_delimiters(8'($urandom), 8'($urandom));
        3: write_delimiters(8'h7E, 8'h7E);
        default: write_delimiters(dfr_pkg::START_BYTE_RST, dfr_pkg::END_BYTE_RST);
      endcase
      sender_steady = (s == 2);
      target = N_DIRECTED + (s + 1) * RANDOM_BYTES / NUM_SETTINGS;
      if (s == 1) send_frame(PAYLOAD_CAP);
      while (bytes_sent < target) begin
        if ($urandom_range(0, 9) < 8) send_frame(-1);
        else send_byte(8'($urandom), 1'b0, R_NONE);
        if ($urandom_range(0, 30) == 0) drain_outputs();
      end
    end

    drain_outputs();
    repeat (8) @(posedge clk);

    $display("Run covered %0d input bytes and %0d checked results over %0d delimiter settings.",
             bytes_sent, results_checked, NUM_SETTINGS + 1);
    $display("%0d frames were read out and %0d bytes ended in an error status.",
             frames_good, error_results);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/dfr_pkg.sv
sv/dfr_front.sv
sv/dfr_queue.sv
sv/dfr_back.sv
sv/framed_byte_deframer_crc8.sv
bench/tb_framed_byte_deframer_crc8.sv
